>>> src/nbm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_pkg
// shared constants, codes and controller/datapath structs for the
// process-name blocklist matcher
// ---------------------------------------------------------------------------
package nbm_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int NAME_BYTES    = 16;
	localparam int NAME_W        = 8 * NAME_BYTES;
	localparam int HALF_W        = NAME_W / 2;
	localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 4;
	localparam int VERDICT_W = 2;
	localparam int REG_W     = 1;

	localparam logic [CMD_W-1:0] CMD_WR_PATTERN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_FLAGS   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_ALLOW = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DENY  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_PRIOR = 2'd2;

	localparam logic [REG_W-1:0] REG_ENFORCE = 1'd0;
	localparam logic [REG_W-1:0] REG_LOG_ALL = 1'd1;

	typedef struct packed {
		logic              take;
		logic              capture;
		logic              issue;
		logic [ADDR_W-1:0] rd_addr;
		logic              load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

>>> src/nbm_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_req_if
// request channel: table writes and name checks
// ---------------------------------------------------------------------------
interface nbm_req_if;
	logic                          valid;
	logic                          ready;
	logic [nbm_pkg::CMD_W-1:0]     command;
	logic [nbm_pkg::INDEX_W-1:0]   entry_index;
	logic                          half_select;
	logic [nbm_pkg::HALF_W-1:0]    pattern_word;
	logic                          exact_flag;
	logic                          enable_flag;
	logic [nbm_pkg::HALF_W-1:0]    name_low;
	logic [nbm_pkg::HALF_W-1:0]    name_high;
	logic                          prior_denied;

	modport source (
		output valid, command, entry_index, half_select, pattern_word,
		       exact_flag, enable_flag, name_low, name_high, prior_denied,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, half_select, pattern_word,
		       exact_flag, enable_flag, name_low, name_high, prior_denied,
		output ready
	);
endinterface
`default_nettype wire

>>> src/nbm_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_rsp_if
// result channel: verdict of one check
// ---------------------------------------------------------------------------
interface nbm_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [nbm_pkg::VERDICT_W-1:0]   verdict;
	logic                            blocked;
	logic                            log_event;

	modport source (output valid, verdict, blocked, log_event, input ready);
	modport sink (input valid, verdict, blocked, log_event, output ready);
endinterface
`default_nettype wire

>>> src/nbm_cfg_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_cfg_if
// register write channel
// ---------------------------------------------------------------------------
interface nbm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [nbm_pkg::REG_W-1:0]   index;
	logic                        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/name_blocklist_matcher_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// name_blocklist_matcher_top
// process-name blocklist matcher: 16-entry pattern table, exact or
// substring match, verdict and log decision per check
//
//   channel  dir  handshake      carries
//   req      in   valid/ready    command, entry, pattern half, flags, name
//   rsp      out  valid/ready    verdict, blocked, log_event
//   cfg      in   valid/ready    register index, write data (ready tied high)
//
// a check walks the table one entry per cycle through the pattern ram read port,
// then loads its result into the output register and returns to idle; a prior
// denial skips the walk and loads its result directly; reset clears the entry
// flags and the log-all register and sets enforce, all at once; pattern ram
// needs no clearing
// a stalled result waits in the output register; a new request is still taken,
// and only a finished check waits for that register to free up
// ---------------------------------------------------------------------------
module name_blocklist_matcher_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	nbm_req_if.sink      req,
	nbm_rsp_if.source    rsp,
	nbm_cfg_if.sink      cfg
);
	nbm_pkg::ctl_cmd_t     cmd;
	nbm_pkg::dp_status_t   status;
	logic                  req_ready;

	assign req.ready = req_ready;
	assign cfg.ready = 1'b1;

	nbm_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req.valid),
		.req_command      (req.command),
		.req_prior_denied (req.prior_denied),
		.req_ready        (req_ready),
		.cmd              (cmd),
		.status           (status)
	);

	nbm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.command       (req.command),
		.entry_index   (req.entry_index),
		.half_select   (req.half_select),
		.pattern_word  (req.pattern_word),
		.exact_flag    (req.exact_flag),
		.enable_flag   (req.enable_flag),
		.name_low      (req.name_low),
		.name_high     (req.name_high),
		.prior_denied  (req.prior_denied),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_verdict   (rsp.verdict),
		.out_blocked   (rsp.blocked),
		.out_log_event (rsp.log_event)
	);

endmodule
`default_nettype wire

>>> src/nbm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module nbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output      logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/nbm_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_ctrl
// sequencer: takes requests, walks the table once per check unless it is
// prior-denied, hands the result to the datapath output register
// ---------------------------------------------------------------------------
module nbm_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic [nbm_pkg::CMD_W-1:0]     req_command,
	input  wire logic                          req_prior_denied,
	output      logic                          req_ready,
	output      nbm_pkg::ctl_cmd_t             cmd,
	input  wire nbm_pkg::dp_status_t           status
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_POST = 3'b100
	} state_t;

	state_t                      state_q;
	logic [nbm_pkg::CNT_W-1:0]   cnt_q;
	logic                        take;
	logic                        scan_more;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_valid && req_ready;
	assign scan_more = (cnt_q != nbm_pkg::CNT_W'(nbm_pkg::TABLE_ENTRIES));

	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		cmd.capture  = take && (req_command == nbm_pkg::CMD_CHECK);
		cmd.issue    = (state_q == ST_SCAN) && scan_more;
		cmd.rd_addr  = cnt_q[nbm_pkg::ADDR_W-1:0];
		cmd.load_out = (state_q == ST_POST) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (take && req_command == nbm_pkg::CMD_CHECK) begin
						state_q <= req_prior_denied ? ST_POST : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						cnt_q <= cnt_q + nbm_pkg::CNT_W'(1);
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/nbm_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbm_dp
// datapath: pattern ram, entry flags, registers, match logic for one entry
// per cycle, hit accumulator and result register
// ---------------------------------------------------------------------------
module nbm_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire nbm_pkg::ctl_cmd_t               cmd,
	output      nbm_pkg::dp_status_t             status,
	input  wire logic [nbm_pkg::CMD_W-1:0]       command,
	input  wire logic [nbm_pkg::INDEX_W-1:0]     entry_index,
	input  wire logic                            half_select,
	input  wire logic [nbm_pkg::HALF_W-1:0]      pattern_word,
	input  wire logic                            exact_flag,
	input  wire logic                            enable_flag,
	input  wire logic [nbm_pkg::HALF_W-1:0]      name_low,
	input  wire logic [nbm_pkg::HALF_W-1:0]      name_high,
	input  wire logic                            prior_denied,
	input  wire logic                            cfg_we,
	input  wire logic [nbm_pkg::REG_W-1:0]       cfg_index,
	input  wire logic                            cfg_data,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [nbm_pkg::VERDICT_W-1:0]   out_verdict,
	output      logic                            out_blocked,
	output      logic                            out_log_event
);
	localparam int NB = nbm_pkg::NAME_BYTES;

	logic                                  idx_ok;
	logic [nbm_pkg::ADDR_W-1:0]            waddr;
	logic                                  we_lo;
	logic                                  we_hi;
	logic [nbm_pkg::HALF_W-1:0]            rd_lo;
	logic [nbm_pkg::HALF_W-1:0]            rd_hi;
	logic [nbm_pkg::NAME_W-1:0]            pat_w;
	logic [nbm_pkg::TABLE_ENTRIES-1:0]     exact_q;
	logic [nbm_pkg::TABLE_ENTRIES-1:0]     enable_q;
	logic                                  enforce_q;
	logic                                  log_all_q;
	logic [nbm_pkg::NAME_W-1:0]            name_q;
	logic                                  prior_q;
	logic                                  valid_s1;
	logic [nbm_pkg::ADDR_W-1:0]            idx_s1;
	logic                                  hit_q;
	logic                                  out_valid_q;
	logic [nbm_pkg::VERDICT_W-1:0]         verdict_q;
	logic                                  blocked_q;
	logic                                  log_q;

	logic [7:0]                            pb [NB];
	logic [7:0]                            nb [NB];
	logic [NB-1:0]                         pnz;
	logic [NB-1:0]                         nnz;
	logic [NB-1:0]                         same;
	logic [NB-1:0]                         plive;
	logic [NB-1:0]                         nlive;
	logic [NB-1:0]                         same_pre;
	logic [NB-1:0]                         sub_vec;
	logic                                  start_ok;
	logic                                  exact_m;
	logic                                  sub_m;
	logic                                  entry_hit;

	// table writes
	assign idx_ok = (32'(entry_index) < nbm_pkg::TABLE_ENTRIES);
	assign waddr  = nbm_pkg::ADDR_W'(entry_index);
	assign we_lo  = cmd.take && command == nbm_pkg::CMD_WR_PATTERN && idx_ok && !half_select;
	assign we_hi  = cmd.take && command == nbm_pkg::CMD_WR_PATTERN && idx_ok && half_select;

	nbm_ram #(
		.WIDTH (nbm_pkg::HALF_W),
		.DEPTH (nbm_pkg::TABLE_ENTRIES)
	) u_ram_lo (
		.clk   (clk),
		.we    (we_lo),
		.waddr (waddr),
		.wdata (pattern_word),
		.re    (cmd.issue),
		.raddr (cmd.rd_addr),
		.rdata (rd_lo)
	);

	nbm_ram #(
		.WIDTH (nbm_pkg::HALF_W),
		.DEPTH (nbm_pkg::TABLE_ENTRIES)
	) u_ram_hi (
		.clk   (clk),
		.we    (we_hi),
		.waddr (waddr),
		.wdata (pattern_word),
		.re    (cmd.issue),
		.raddr (cmd.rd_addr),
		.rdata (rd_hi)
	);

	assign pat_w = {rd_hi, rd_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_q   <= '0;
			enable_q  <= '0;
			enforce_q <= 1'b1;
			log_all_q <= 1'b0;
		end else begin
			if (cmd.take && command == nbm_pkg::CMD_WR_FLAGS && idx_ok) begin
				exact_q[waddr]  <= exact_flag;
				enable_q[waddr] <= enable_flag;
			end
			if (cfg_we) begin
				case (cfg_index)
					nbm_pkg::REG_ENFORCE: enforce_q <= cfg_data;
					nbm_pkg::REG_LOG_ALL: log_all_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// match logic for the entry read last cycle
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			pb[k]   = pat_w[8*k +: 8];
			nb[k]   = name_q[8*k +: 8];
			pnz[k]  = (pb[k] != 8'd0);
			nnz[k]  = (nb[k] != 8'd0);
			same[k] = (pb[k] == nb[k]);
		end
		for (int j = 0; j < NB; j++) begin
			plive[j]    = 1'b1;
			nlive[j]    = 1'b1;
			same_pre[j] = 1'b1;
			for (int k = 0; k < NB; k++) begin
				if (k <= j) begin
					plive[j]    = plive[j] & pnz[k];
					nlive[j]    = nlive[j] & nnz[k];
					same_pre[j] = same_pre[j] & same[k];
				end
			end
		end
		exact_m = |(~pnz & same_pre);
		for (int i = 0; i < NB; i++) begin
			start_ok = nlive[i];
			for (int j = 0; j < NB; j++) begin
				if (plive[j]) begin
					if (i + j < NB) begin
						start_ok = start_ok & (nb[i+j] == pb[j]);
					end else begin
						start_ok = 1'b0;
					end
				end
			end
			sub_vec[i] = start_ok;
		end
		sub_m     = |sub_vec;
		entry_hit = enable_q[idx_s1] && pnz[0] && (exact_q[idx_s1] ? exact_m : sub_m);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			name_q  <= {name_high, name_low};
			prior_q <= prior_denied;
		end
		idx_s1 <= cmd.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (valid_s1 && entry_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	// result register
	assign status.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (prior_q) begin
				verdict_q <= nbm_pkg::VERDICT_PRIOR;
				blocked_q <= 1'b0;
				log_q     <= 1'b0;
			end else begin
				verdict_q <= (hit_q && enforce_q) ? nbm_pkg::VERDICT_DENY
				                                  : nbm_pkg::VERDICT_ALLOW;
				blocked_q <= hit_q;
				log_q     <= hit_q || log_all_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_verdict   = verdict_q;
	assign out_blocked   = blocked_q;
	assign out_log_event = log_q;

endmodule
`default_nettype wire
